/* rtl/core/vgd_pkg.sv */
// ----------------------------------------------------------------------------
// vgd_pkg
// types and constants shared by the voxel grid downsampler
// ----------------------------------------------------------------------------
package vgd_pkg;

  localparam int COORD_W    = 24;
  localparam int COUNT_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int SUMC_W     = COORD_W + COUNT_W;
  localparam int SUMK_W     = COLOR_W + COUNT_W;
  localparam int CSIZE_W    = 23;
  localparam int DIM_W      = 5;
  localparam int DIM_EW     = 7;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_EMIT  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_CELL_SIZE = 3'd3,
    CFG_DIM_X     = 3'd4,
    CFG_DIM_Y     = 3'd5,
    CFG_DIM_Z     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] avg_x;
    logic signed [COORD_W-1:0] avg_y;
    logic signed [COORD_W-1:0] avg_z;
    logic [COLOR_W-1:0]        avg_red;
    logic [COLOR_W-1:0]        avg_green;
    logic [COLOR_W-1:0]        avg_blue;
    logic [COUNT_W-1:0]        cell_points;
    logic [IDX_W-1:0]          cell_index;
    logic                      done_res;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic signed [SUMC_W-1:0] sum_x;
    logic signed [SUMC_W-1:0] sum_y;
    logic signed [SUMC_W-1:0] sum_z;
    logic [SUMK_W-1:0]        sum_red;
    logic [SUMK_W-1:0]        sum_green;
    logic [SUMK_W-1:0]        sum_blue;
  } cell_word_t;

endpackage

/* rtl/core/vgd_ram.sv */
// ----------------------------------------------------------------------------
// vgd_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/vgd_div.sv */
// ----------------------------------------------------------------------------
// vgd_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vgd_div #(
  parameter int NW = 40,
  parameter int DW = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    den_q;
  logic [DW-1:0]    rem_q;
  logic [NW-1:0]    quo_q;
  logic [DW:0]      trial;
  logic             ge;
  logic [DW-1:0]    rem_d;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

/* rtl/core/voxel_grid_downsample.sv */
// ----------------------------------------------------------------------------
// voxel_grid_downsample
// voxel grid point cloud downsampler with per-cell centroid output
// ----------------------------------------------------------------------------
// One item is in work at a time. An add beat runs a restoring division per
// axis (the three axes run side by side), then, for a point in the grid, a
// read-modify-write of the cell word in the grid ram. An emit beat reads and
// then checks each cell that the scan passes over, runs the six averaging
// dividers on the first cell that holds points, then loads the output
// register and returns to idle for the next beat; a finished scan answers
// done without scanning. A clear beat starts a clearing pass over all
// MAX_DIM**3 cells of the grid ram (4096 by default) and the same pass runs
// once after reset; no beat is taken during it, config writes are. The output
// register lets the next beat in while a result waits.
module voxel_grid_downsample #(
  parameter int MAX_DIM = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  vgd_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output vgd_pkg::out_item_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [vgd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [vgd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  import vgd_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SPW   = $clog2(CELLS + 1);
  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIVI  = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_SCHK  = 8'b0010_0000,
    S_DIVA  = 8'b0100_0000,
    S_PUSH  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic signed [COORD_W-1:0] org_q [3];
  logic [CSIZE_W-1:0]        csize_q;
  logic [DIM_W-1:0]          dim_q [3];
  logic [DIM_EW-1:0]         dim_eff [3];
  logic [CSIZE_W-1:0]        csize_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        org_q[a] <= '0;
        dim_q[a] <= DIM_W'(16);
      end
      csize_q <= CSIZE_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:  org_q[0] <= cfg_wdata_i[COORD_W-1:0];
        CFG_ORIGIN_Y:  org_q[1] <= cfg_wdata_i[COORD_W-1:0];
        CFG_ORIGIN_Z:  org_q[2] <= cfg_wdata_i[COORD_W-1:0];
        CFG_CELL_SIZE: csize_q  <= cfg_wdata_i[CSIZE_W-1:0];
        CFG_DIM_X:     dim_q[0] <= cfg_wdata_i[DIM_W-1:0];
        CFG_DIM_Y:     dim_q[1] <= cfg_wdata_i[DIM_W-1:0];
        CFG_DIM_Z:     dim_q[2] <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // dims saturate at the grid size, zero cell size acts as one
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dim_eff[a] = (DIM_EW'(dim_q[a]) > DIM_EW'(MAX_DIM)) ? DIM_EW'(MAX_DIM)
                                                          : DIM_EW'(dim_q[a]);
    end
    csize_eff = (csize_q == '0) ? CSIZE_W'(1) : csize_q;
  end

  // datapath registers
  in_item_t           pt_q;
  logic [2:0]         neg_q;
  logic [AW-1:0]      addr_q;
  logic [AW-1:0]      clr_q;
  logic [SPW-1:0]     scan_q;
  logic [CW-1:0]      sx_q, sy_q, sz_q;
  logic               indim_q;
  logic [COUNT_W-1:0] n_q;
  logic [AW-1:0]      cidx_q;
  logic               res_done_q;
  out_item_t          out_q;
  logic               out_valid_q;

  // grid ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, add_addr;
  cell_word_t    ram_wdata, ram_rdata, upd_word;

  vgd_ram #(
    .WIDTH ($bits(cell_word_t)),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // dividers: three wide ones for cell index and position, three for colour
  logic                  add_start, avg_start;
  logic [SUMC_W-1:0]     cnum [3];
  logic [SUMC_W-1:0]     cq   [3];
  logic [2:0]            cbusy;
  logic [SUMK_W-1:0]     knum [3];
  logic [SUMK_W-1:0]     kq   [3];
  logic [2:0]            kbusy;
  logic [CSIZE_W-1:0]    cden;
  logic [COORD_W:0]      diff [3];
  logic signed [COORD_W-1:0] pin [3];
  logic signed [SUMC_W-1:0]  rsum [3];
  logic [SUMK_W-1:0]         rcol [3];

  always_comb begin
    pin[0]  = in_data_i.x_coord;
    pin[1]  = in_data_i.y_coord;
    pin[2]  = in_data_i.z_coord;
    rsum[0] = ram_rdata.sum_x;
    rsum[1] = ram_rdata.sum_y;
    rsum[2] = ram_rdata.sum_z;
    rcol[0] = ram_rdata.sum_red;
    rcol[1] = ram_rdata.sum_green;
    rcol[2] = ram_rdata.sum_blue;
    for (int a = 0; a < 3; a++) begin
      diff[a] = {pin[a][COORD_W-1], pin[a]} - {org_q[a][COORD_W-1], org_q[a]};
      // index division on add, magnitude of the sum on emit
      cnum[a] = add_start ? SUMC_W'(diff[a][COORD_W-1:0])
              : (rsum[a][SUMC_W-1] ? SUMC_W'(~rsum[a] + 1'b1) : SUMC_W'(rsum[a]));
      knum[a] = rcol[a];
    end
    cden = add_start ? csize_eff : CSIZE_W'(ram_rdata.count);
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    vgd_div #(
      .NW (SUMC_W),
      .DW (CSIZE_W)
    ) u_cdiv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (add_start | avg_start),
      .num_i   (cnum[a]),
      .den_i   (cden),
      .busy_o  (cbusy[a]),
      .quot_o  (cq[a])
    );

    vgd_div #(
      .NW (SUMK_W),
      .DW (COUNT_W)
    ) u_kdiv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (avg_start),
      .num_i   (knum[a]),
      .den_i   (ram_rdata.count),
      .busy_o  (kbusy[a]),
      .quot_o  (kq[a])
    );
  end

  // cell of the point and whether it is kept
  logic idx_ok;
  always_comb begin
    idx_ok = ~|neg_q;
    for (int a = 0; a < 3; a++) begin
      if (cq[a] >= SUMC_W'(dim_eff[a])) begin
        idx_ok = 1'b0;
      end
    end
    add_addr = AW'(int'(cq[0][CW-1:0]) * (MAX_DIM * MAX_DIM)
                 + int'(cq[1][CW-1:0]) * MAX_DIM + int'(cq[2][CW-1:0]));
  end

  // read-modify-write of one cell; the first point overwrites stale sums
  logic cell_full, cell_empty;
  always_comb begin
    cell_full  = &ram_rdata.count;
    cell_empty = ram_rdata.count == '0;
    upd_word.count = ram_rdata.count + 1'b1;
    if (cell_empty) begin
      upd_word.sum_x     = SUMC_W'(pt_q.x_coord);
      upd_word.sum_y     = SUMC_W'(pt_q.y_coord);
      upd_word.sum_z     = SUMC_W'(pt_q.z_coord);
      upd_word.sum_red   = SUMK_W'(pt_q.red);
      upd_word.sum_green = SUMK_W'(pt_q.green);
      upd_word.sum_blue  = SUMK_W'(pt_q.blue);
    end else begin
      upd_word.sum_x     = ram_rdata.sum_x + SUMC_W'(pt_q.x_coord);
      upd_word.sum_y     = ram_rdata.sum_y + SUMC_W'(pt_q.y_coord);
      upd_word.sum_z     = ram_rdata.sum_z + SUMC_W'(pt_q.z_coord);
      upd_word.sum_red   = ram_rdata.sum_red + SUMK_W'(pt_q.red);
      upd_word.sum_green = ram_rdata.sum_green + SUMK_W'(pt_q.green);
      upd_word.sum_blue  = ram_rdata.sum_blue + SUMK_W'(pt_q.blue);
    end
  end

  logic in_acc, scan_end, push_ok;
  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign scan_end  = scan_q == SPW'(CELLS);
  assign push_ok   = !out_valid_q || !out_stall_i;
  assign add_start = in_acc && (in_data_i.action == ACT_ADD);
  assign avg_start = (state_q == S_SCHK) && indim_q && !cell_empty;

  always_comb begin
    ram_we    = (state_q == S_CLEAR) || ((state_q == S_ADD) && !cell_full);
    ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
    ram_wdata = (state_q == S_CLEAR) ? cell_word_t'('0) : upd_word;
    ram_raddr = (state_q == S_DIVI) ? add_addr : scan_q[AW-1:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(CELLS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.action)
            ACT_ADD:   state_d = S_DIVI;
            ACT_EMIT:  state_d = scan_end ? S_PUSH : S_SCAN;
            ACT_CLEAR: state_d = S_CLEAR;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_DIVI: if (!cbusy[0]) state_d = idx_ok ? S_ADD : S_IDLE;
      S_ADD:  state_d = S_IDLE;
      S_SCAN: state_d = scan_end ? S_PUSH : S_SCHK;
      S_SCHK: state_d = avg_start ? S_DIVA : S_SCAN;
      S_DIVA: if (!cbusy[0] && !kbusy[0]) state_d = S_PUSH;
      S_PUSH: if (push_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      scan_q      <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sz_q        <= '0;
      out_valid_q <= 1'b0;
      res_done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc && (in_data_i.action == ACT_CLEAR)) begin
        clr_q  <= '0;
        scan_q <= '0;
        sx_q   <= '0;
        sy_q   <= '0;
        sz_q   <= '0;
      end
      if (in_acc && (in_data_i.action == ACT_EMIT)) begin
        res_done_q <= scan_end;
      end
      // scan pointer walks z fastest, then y, then x
      if ((state_q == S_SCAN) && !scan_end) begin
        scan_q <= scan_q + 1'b1;
        if (sz_q == CW'(MAX_DIM - 1)) begin
          sz_q <= '0;
          if (sy_q == CW'(MAX_DIM - 1)) begin
            sy_q <= '0;
            sx_q <= sx_q + 1'b1;
          end else begin
            sy_q <= sy_q + 1'b1;
          end
        end else begin
          sz_q <= sz_q + 1'b1;
        end
      end
      if (state_q == S_SCAN) begin
        res_done_q <= scan_end;
      end
      if ((state_q == S_PUSH) && push_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_start) begin
      pt_q  <= in_data_i;
      neg_q <= {diff[2][COORD_W], diff[1][COORD_W], diff[0][COORD_W]};
    end
    if ((state_q == S_DIVI) && !cbusy[0]) begin
      addr_q <= add_addr;
    end
    if (state_q == S_SCAN) begin
      cidx_q  <= scan_q[AW-1:0];
      indim_q <= (DIM_EW'(sx_q) < dim_eff[0]) && (DIM_EW'(sy_q) < dim_eff[1])
              && (DIM_EW'(sz_q) < dim_eff[2]);
    end
    if (avg_start) begin
      neg_q <= {ram_rdata.sum_z[SUMC_W-1], ram_rdata.sum_y[SUMC_W-1],
                ram_rdata.sum_x[SUMC_W-1]};
      n_q   <= ram_rdata.count;
    end
    if ((state_q == S_PUSH) && push_ok) begin
      if (res_done_q) begin
        out_q <= '{done_res: 1'b1, default: '0};
      end else begin
        out_q.avg_x       <= neg_q[0] ? ~cq[0][COORD_W-1:0] + 1'b1 : cq[0][COORD_W-1:0];
        out_q.avg_y       <= neg_q[1] ? ~cq[1][COORD_W-1:0] + 1'b1 : cq[1][COORD_W-1:0];
        out_q.avg_z       <= neg_q[2] ? ~cq[2][COORD_W-1:0] + 1'b1 : cq[2][COORD_W-1:0];
        out_q.avg_red     <= kq[0][COLOR_W-1:0];
        out_q.avg_green   <= kq[1][COLOR_W-1:0];
        out_q.avg_blue    <= kq[2][COLOR_W-1:0];
        out_q.cell_points <= n_q;
        out_q.cell_index  <= IDX_W'(cidx_q);
        out_q.done_res    <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // done beats carry no cell
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.cell_points == '0)
    else $error("done result with nonzero count");

  // a cell result always averages at least one point
  a_cell_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.cell_points != '0)
    else $error("cell result with zero count");

  // the grid ram is only written by the clearing pass or an add
  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR) || (state_q == S_ADD))
    else $error("unexpected grid ram write");
`endif

endmodule

/* bench/voxel_grid_downsample_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_grid_downsample_tb
// self-checking bench: point beats are binned into a local grid model and
// every emit beat is checked against the centroid that the model computes
// ----------------------------------------------------------------------------
module voxel_grid_downsample_tb;
  import vgd_pkg::*;

  localparam int NDIM        = 16;
  localparam int NCELLS      = NDIM * NDIM * NDIM;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int CYCLE_LIMIT = 40000000;
  localparam int SETTLE      = 100;   // an add beat gives no result
  localparam int HOLD_AT     = 150;   // result number that arms the long hold
  localparam int HOLD_LEN    = 700;
  localparam int IN_W        = $bits(in_item_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  voxel_grid_downsample dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // grid model: registers, per-cell sums and counts, scan position
  // --------------------------------------------------------------------------
  longint      org_x, org_y, org_z;
  int unsigned csize, dx, dy, dz;
  int unsigned pts_cnt [NCELLS];
  longint      sx [NCELLS], sy [NCELLS], sz [NCELLS];
  int unsigned sr [NCELLS], sg [NCELLS], sb [NCELLS];
  int unsigned scan_ptr;

  out_item_t centroid_q [$];   // centroids still owed by the block
  in_item_t  point_q [$];      // beats waiting for the driver
  int        errors = 0;
  int        n_results = 0;
  bit        calm = 1'b0;      // no idling on either side
  longint    cycles = 0;

  function automatic int unsigned sat_dim(int unsigned d);
    return (d > NDIM) ? NDIM : d;
  endfunction

  // cell coordinate on one axis, -1 when the point falls outside
  function automatic int voxel_axis(logic signed [COORD_W-1:0] c, longint org,
                                    int unsigned dim);
    longint d;
    longint cs;
    longint q;
    d  = longint'(c) - org;
    cs = (csize == 0) ? 1 : csize;
    if (d < 0) return -1;
    q = d / cs;
    if (q >= sat_dim(dim)) return -1;
    return int'(q);
  endfunction

  // apply one accepted beat to the grid model, queue a centroid for emit
  task automatic bin_point_beat(in_item_t it);
    int        cx, cy, cz, c;
    int        n;
    out_item_t res;
    longint    ax, ay, az;
    case (action_e'(it.action))
      ACT_ADD: begin
        cx = voxel_axis(it.x_coord, org_x, dx);
        cy = voxel_axis(it.y_coord, org_y, dy);
        cz = voxel_axis(it.z_coord, org_z, dz);
        if (cx >= 0 && cy >= 0 && cz >= 0) begin
          c = cx * NDIM * NDIM + cy * NDIM + cz;
          if (pts_cnt[c] < COUNT_MAX) begin
            // first point overwrites whatever the sums held
            if (pts_cnt[c] == 0) begin
              sx[c] = 0; sy[c] = 0; sz[c] = 0;
              sr[c] = 0; sg[c] = 0; sb[c] = 0;
            end
            sx[c] += longint'(it.x_coord);
            sy[c] += longint'(it.y_coord);
            sz[c] += longint'(it.z_coord);
            sr[c] += it.red;
            sg[c] += it.green;
            sb[c] += it.blue;
            pts_cnt[c]++;
          end
        end
      end
      ACT_CLEAR: begin
        foreach (pts_cnt[i]) pts_cnt[i] = 0;
        scan_ptr = 0;
      end
      ACT_EMIT: begin
        res = '0;
        res.done_res = 1'b1;
        while (scan_ptr < NCELLS) begin
          c = scan_ptr;
          n = pts_cnt[c];
          scan_ptr++;
          if ((c / (NDIM * NDIM)) < sat_dim(dx) && ((c / NDIM) % NDIM) < sat_dim(dy) &&
              (c % NDIM) < sat_dim(dz) && n != 0) begin
            // longint division truncates toward zero
            ax = sx[c] / n;
            ay = sy[c] / n;
            az = sz[c] / n;
            res.avg_x       = ax[COORD_W-1:0];
            res.avg_y       = ay[COORD_W-1:0];
            res.avg_z       = az[COORD_W-1:0];
            res.avg_red     = COLOR_W'(sr[c] / n);
            res.avg_green   = COLOR_W'(sg[c] / n);
            res.avg_blue    = COLOR_W'(sb[c] / n);
            res.cell_points = COUNT_W'(n);
            res.cell_index  = IDX_W'(c);
            res.done_res    = 1'b0;
            break;
          end
        end
        centroid_q.push_back(res);
      end
      default: ;  // nop beat leaves everything alone
    endcase
  endtask

  // --------------------------------------------------------------------------
  // driver: offers queued beats, random gaps between them
  // --------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      bin_point_beat(in_data);
      void'(point_q.pop_front());
    end
    if (in_valid && in_stall) begin
      // stalled beat stays put
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (point_q.size() != 0 && rst_ni) begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(1, 18) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= point_q[0];
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random stall bursts, field-by-field checks
  // --------------------------------------------------------------------------
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_on = 1'b0;
  bit   hold_done = 1'b0;
  logic stall_rnd = 1'b0;

  assign out_stall = stall_rnd | hold_on;

  task automatic check_field(string name, longint exp, longint act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t exp;
    if (out_valid && !out_stall) begin
      n_results++;
      if (centroid_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %p", $time, out_data);
        errors++;
      end else begin
        exp = centroid_q.pop_front();
        check_field("avg_x",       exp.avg_x,       out_data.avg_x);
        check_field("avg_y",       exp.avg_y,       out_data.avg_y);
        check_field("avg_z",       exp.avg_z,       out_data.avg_z);
        check_field("avg_red",     exp.avg_red,     out_data.avg_red);
        check_field("avg_green",   exp.avg_green,   out_data.avg_green);
        check_field("avg_blue",    exp.avg_blue,    out_data.avg_blue);
        check_field("cell_points", exp.cell_points, out_data.cell_points);
        check_field("cell_index",  exp.cell_index,  out_data.cell_index);
        check_field("done_res",    exp.done_res,    out_data.done_res);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      stall_rnd  <= (stall_left > 1);
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      stall_rnd  <= 1'b1;
    end else begin
      stall_rnd <= 1'b0;
    end
  end

  // long hold while the sender still has beats, so the block backs up
  always @(posedge clk_i) begin
    if (!hold_done && n_results >= HOLD_AT && point_q.size() > 20) begin
      hold_done <= 1'b1;
      hold_on   <= 1'b1;
      hold_left <= HOLD_LEN - 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_on <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ORIGIN_X:  org_x = longint'($signed(val));
      CFG_ORIGIN_Y:  org_y = longint'($signed(val));
      CFG_ORIGIN_Z:  org_z = longint'($signed(val));
      CFG_CELL_SIZE: csize = val[CSIZE_W-1:0];
      CFG_DIM_X:     dx = val[DIM_W-1:0];
      CFG_DIM_Y:     dy = val[DIM_W-1:0];
      CFG_DIM_Z:     dz = val[DIM_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mk_beat(action_e act, int x, int y, int z,
                                       int r, int g, int b);
    in_item_t it;
    it.action  = act;
    it.x_coord = x[COORD_W-1:0];
    it.y_coord = y[COORD_W-1:0];
    it.z_coord = z[COORD_W-1:0];
    it.red     = r[7:0];
    it.green   = g[7:0];
    it.blue    = b[7:0];
    return it;
  endfunction

  // coordinate inside the grid, biased toward the first few cells
  function automatic int grid_coord(longint org, int unsigned dim);
    int unsigned d;
    int unsigned cs;
    int unsigned cell_no;
    longint v;
    d       = sat_dim(dim);
    cs      = (csize == 0) ? 1 : csize;
    cell_no = ($urandom_range(0, 1) == 0) ? $urandom_range(0, (d > 2) ? 1 : d - 1)
                                           : $urandom_range(0, d - 1);
    v = org + longint'(cell_no) * cs + $urandom_range(0, cs - 1);
    return int'(v);
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t it;
    int unsigned pick;
    it   = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 64 && sat_dim(dx) > 0 && sat_dim(dy) > 0 && sat_dim(dz) > 0) begin
      it.action  = ACT_ADD;
      it.x_coord = COORD_W'(grid_coord(org_x, dx));
      it.y_coord = COORD_W'(grid_coord(org_y, dy));
      it.z_coord = COORD_W'(grid_coord(org_z, dz));
    end else if (pick < 72) begin
      it.action = ACT_ADD;              // noise coordinates, mostly dropped
    end else if (pick < 94) begin
      it.action = ACT_EMIT;
    end else if (pick < 97) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_NOP;
    end
    return it;
  endfunction

  task automatic drain();
    while (point_q.size() != 0 || in_valid || centroid_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic setup_grid(int ox, int oy, int oz, int cs, int ex, int ey, int ez);
    write_reg(CFG_ORIGIN_X, ox[23:0]);
    write_reg(CFG_ORIGIN_Y, oy[23:0]);
    write_reg(CFG_ORIGIN_Z, oz[23:0]);
    write_reg(CFG_CELL_SIZE, cs[23:0]);
    write_reg(CFG_DIM_X, ex[23:0]);
    write_reg(CFG_DIM_Y, ey[23:0]);
    write_reg(CFG_DIM_Z, ez[23:0]);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int ox, oy, oz, cs, nph;
    org_x = 0; org_y = 0; org_z = 0;
    csize = 256; dx = NDIM; dy = NDIM; dz = NDIM;
    foreach (pts_cnt[i]) pts_cnt[i] = 0;
    scan_ptr = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: points at the grid corners, below origin and past the end
    point_q.push_back(mk_beat(ACT_ADD, 0, 0, 0, 255, 255, 255));
    point_q.push_back(mk_beat(ACT_ADD, 255, 255, 255, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_ADD, -1, 0, 0, 9, 9, 9));
    point_q.push_back(mk_beat(ACT_ADD, 4096, 0, 0, 9, 9, 9));
    point_q.push_back(mk_beat(ACT_ADD, 8388607, 8388607, 8388607, 1, 1, 1));
    point_q.push_back(mk_beat(ACT_ADD, -8388608, -8388608, -8388608, 1, 1, 1));
    point_q.push_back(mk_beat(ACT_ADD, 4095, 4095, 4095, 1, 2, 3));
    point_q.push_back(mk_beat(ACT_ADD, 256, 512, 768, 200, 100, 50));
    point_q.push_back(mk_beat(ACT_ADD, 300, 600, 800, 7, 11, 13));
    point_q.push_back(mk_beat(ACT_NOP, -5, 77, 8388607, 255, 0, 255));
    repeat (5) point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_ADD, 10, 10, 10, 4, 4, 4));   // scan already finished
    point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_ADD, 300, 0, 0, 3, 3, 3));
    point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    drain();

    // most negative origin, widest cell, one cell per axis: negative centroids
    setup_grid(-8388608, -8388608, -8388608, 8388607, 1, 1, 1);
    point_q.push_back(mk_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_ADD, -8388608, -8388608, -8388608, 255, 0, 1));
    point_q.push_back(mk_beat(ACT_ADD, -3, -1000, -7, 0, 255, 2));
    point_q.push_back(mk_beat(ACT_ADD, 8388607, 0, 0, 5, 5, 5));  // past the grid
    point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    drain();

    // zero cell size acts as one, oversize dimensions saturate
    setup_grid(0, 0, 0, 0, 31, 17, 16);
    point_q.push_back(mk_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_ADD, 15, 3, 0, 1, 2, 3));
    point_q.push_back(mk_beat(ACT_ADD, 16, 3, 0, 1, 2, 3));
    point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    point_q.push_back(mk_beat(ACT_ADD, 2, 2, 2, 8, 8, 8));
    drain();

    // zero dims drop all points, so the emit answers done
    setup_grid(0, 0, 0, 0, 0, 0, 0);
    point_q.push_back(mk_beat(ACT_ADD, 0, 0, 0, 1, 1, 1));
    point_q.push_back(mk_beat(ACT_EMIT, 0, 0, 0, 0, 0, 0));
    drain();

    // random phases; each phase boundary doubles as a sender pause
    nph = 12;
    for (int ph = 0; ph < nph; ph++) begin
      case ($urandom_range(0, 3))
        0: begin ox = $urandom; oy = $urandom; oz = $urandom; end
        default: begin
          ox = $urandom_range(0, 2000) - 1000;
          oy = $urandom_range(0, 2000) - 1000;
          oz = $urandom_range(0, 2000) - 1000;
        end
      endcase
      case ($urandom_range(0, 3))
        0: cs = $urandom_range(1, 64);
        1: cs = 256;
        2: cs = $urandom_range(0, 8388607);
        default: cs = $urandom_range(1, 600);
      endcase
      setup_grid(ox, oy, oz, cs, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                            : $urandom_range(1, 4),
                 $urandom_range(1, 16), $urandom_range(0, 16));
      if (ph == nph - 1) calm = 1'b1;
      if ($urandom_range(0, 2) != 0)
        point_q.push_back(mk_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
      repeat (90) point_q.push_back(rand_beat());
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
